@@ rtl/damped_wave_grid_stencil_unit_defines.svh @@
// Assertion macros shared by the damped wave grid RTL.
// Needs clk and rst_n in the scope where a macro is used.
`ifndef DAMPED_WAVE_GRID_STENCIL_UNIT_DEFINES_SVH
`define DAMPED_WAVE_GRID_STENCIL_UNIT_DEFINES_SVH
// same-cycle implication
`define DWGS_ASSERT_IMPL(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication
`define DWGS_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`endif

@@ rtl/dwgs_pkg.sv @@
// Package for the damped wave grid stencil unit: widths, codes, types, saturation.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package dwgs_pkg;
  localparam int ROW_W      = 6;
  localparam int COL_W      = 6;
  localparam int REQ_W      = 2;
  localparam int H_W        = 24;
  localparam int CX_W       = 15;
  localparam int CY_W       = 15;
  localparam int CC_W       = 18;
  localparam int DAMP_W     = 17;
  localparam int CFG_DATA_W = 18;
  localparam int CFG_IDX_W  = 2;

  localparam int DEF_GRID_ROWS = 64;
  localparam int DEF_GRID_COLS = 64;

  // request codes on the input channel
  localparam logic [REQ_W-1:0] REQ_WRITE   = 2'd0;
  localparam logic [REQ_W-1:0] REQ_ADVANCE = 2'd1;
  localparam logic [REQ_W-1:0] REQ_READ    = 2'd2;

  // decoded operations
  localparam logic [1:0] OP_WRITE   = 2'd0;
  localparam logic [1:0] OP_ADVANCE = 2'd1;
  localparam logic [1:0] OP_READ    = 2'd2;
  localparam logic [1:0] OP_NONE    = 2'd3;

  // position of a cell along one axis
  localparam logic [1:0] POS_FIRST = 2'd0;
  localparam logic [1:0] POS_MID   = 2'd1;
  localparam logic [1:0] POS_LAST  = 2'd2;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_COEF_X      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COEF_Y      = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_COEF_CENTER = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_DAMPING     = 2'd3;

  localparam logic [CX_W-1:0]   RST_COEF_X      = 15'd409;
  localparam logic [CY_W-1:0]   RST_COEF_Y      = 15'd409;
  localparam logic [CC_W-1:0]   RST_COEF_CENTER = 18'd129437;
  localparam logic [DAMP_W-1:0] RST_DAMPING     = 17'd65405;

  typedef struct packed {
    logic [1:0]            op;
    logic [ROW_W-1:0]      row;
    logic [COL_W-1:0]      col;
    logic [1:0]            row_pos;
    logic [1:0]            col_pos;
    logic                  land;
    logic signed [H_W-1:0] add;
  } item_t;

  typedef struct packed {
    logic [CX_W-1:0]   coef_x;
    logic [CY_W-1:0]   coef_y;
    logic [CC_W-1:0]   coef_center;
    logic [DAMP_W-1:0] damping;
  } cfg_t;

  function automatic logic signed [H_W-1:0] sat_h(input logic signed [47:0] v);
    if (v > 48'sh7FFFFF) begin
      return 24'sh7FFFFF;
    end else if (v < -48'sh800000) begin
      return 24'sh800000;
    end else begin
      return v[H_W-1:0];
    end
  endfunction
endpackage
`default_nettype wire

@@ rtl/dwgs_if.sv @@
// Channel interfaces for the damped wave grid stencil unit.
// Depends on dwgs_pkg.
`timescale 1ns / 1ps
`default_nettype none
interface dwgs_in_if;
  logic                              valid;
  logic                              ready;
  logic [dwgs_pkg::REQ_W-1:0]        req_type;
  logic [dwgs_pkg::ROW_W-1:0]        row;
  logic [dwgs_pkg::COL_W-1:0]        col;
  logic                              land_flag;
  logic signed [dwgs_pkg::H_W-1:0]   height_add;
  modport source (output valid, req_type, row, col, land_flag, height_add, input ready);
  modport sink (input valid, req_type, row, col, land_flag, height_add, output ready);
endinterface

interface dwgs_out_if;
  logic                              valid;
  logic                              ready;
  logic signed [dwgs_pkg::H_W-1:0]   height;
  logic signed [dwgs_pkg::H_W-1:0]   normal_x;
  logic signed [dwgs_pkg::H_W-1:0]   normal_y;
  modport source (output valid, height, normal_x, normal_y, input ready);
  modport sink (input valid, height, normal_x, normal_y, output ready);
endinterface
`default_nettype wire

@@ rtl/dwgs_front.sv @@
// Front end: accepts request transactions, classifies them, two-entry queue.
// Depends on dwgs_pkg and dwgs_if.
`timescale 1ns / 1ps
`default_nettype none
module dwgs_front #(
  parameter int GRID_ROWS = dwgs_pkg::DEF_GRID_ROWS,
  parameter int GRID_COLS = dwgs_pkg::DEF_GRID_COLS
) (
  input  logic              clk,
  input  logic              rst_n,
  dwgs_in_if.sink           in_ch,
  input  logic              hold,
  output dwgs_pkg::item_t   head,
  output logic              head_valid,
  input  logic              pop
);
  dwgs_pkg::item_t q_r [2];
  logic            wp_r, rp_r;
  logic [1:0]      cnt_r;
  logic            push;
  logic            in_grid;
  dwgs_pkg::item_t itm;

  assign in_ch.ready = (cnt_r != 2'd2) && !hold;
  assign push        = in_ch.valid && in_ch.ready;
  assign head        = q_r[rp_r];
  assign head_valid  = (cnt_r != 2'd0);

  always_comb begin
    in_grid = (32'(in_ch.row) < 32'(GRID_ROWS)) && (32'(in_ch.col) < 32'(GRID_COLS));
    itm.row  = in_ch.row;
    itm.col  = in_ch.col;
    itm.land = in_ch.land_flag;
    itm.add  = in_ch.height_add;
    if (in_ch.row == '0) begin
      itm.row_pos = dwgs_pkg::POS_FIRST;
    end else if (32'(in_ch.row) == 32'(GRID_ROWS - 1)) begin
      itm.row_pos = dwgs_pkg::POS_LAST;
    end else begin
      itm.row_pos = dwgs_pkg::POS_MID;
    end
    if (in_ch.col == '0) begin
      itm.col_pos = dwgs_pkg::POS_FIRST;
    end else if (32'(in_ch.col) == 32'(GRID_COLS - 1)) begin
      itm.col_pos = dwgs_pkg::POS_LAST;
    end else begin
      itm.col_pos = dwgs_pkg::POS_MID;
    end
    case (in_ch.req_type)
      dwgs_pkg::REQ_WRITE:   itm.op = in_grid ? dwgs_pkg::OP_WRITE : dwgs_pkg::OP_NONE;
      dwgs_pkg::REQ_ADVANCE: itm.op = dwgs_pkg::OP_ADVANCE;
      dwgs_pkg::REQ_READ:    itm.op = in_grid ? dwgs_pkg::OP_READ : dwgs_pkg::OP_NONE;
      default:               itm.op = dwgs_pkg::OP_NONE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wp_r] <= itm;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) begin
        wp_r <= ~wp_r;
      end
      if (pop) begin
        rp_r <= ~rp_r;
      end
      case ({push, pop})
        2'b10:   cnt_r <= cnt_r + 2'd1;
        2'b01:   cnt_r <= cnt_r - 2'd1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end
endmodule
`default_nettype wire

@@ rtl/dwgs_back.sv @@
// Back end: height banks, land mask, clearing pass, write/read sequencer and
// the pipelined stencil sweep. Depends on dwgs_pkg, dwgs_if and the defines header.
`timescale 1ns / 1ps
`default_nettype none
`include "damped_wave_grid_stencil_unit_defines.svh"
module dwgs_back #(
  parameter int GRID_ROWS = dwgs_pkg::DEF_GRID_ROWS,
  parameter int GRID_COLS = dwgs_pkg::DEF_GRID_COLS
) (
  input  logic              clk,
  input  logic              rst_n,
  input  dwgs_pkg::item_t   item,
  input  logic              item_valid,
  output logic              item_pop,
  output logic              clearing,
  input  dwgs_pkg::cfg_t    cfg,
  dwgs_out_if.source        out_ch
);
  localparam int CELLS = GRID_ROWS * GRID_COLS;
  localparam int AW    = $clog2(CELLS);
  localparam int RW    = $clog2(GRID_ROWS);
  localparam int CW    = $clog2(GRID_COLS);
  localparam int SHD   = 2 * GRID_COLS + 1;
  localparam int N_END = CELLS + GRID_COLS + 6;
  localparam int NW    = $clog2(N_END + 1);
  localparam int HW    = dwgs_pkg::H_W;
  localparam logic signed [9:0] RM1 = 10'(GRID_ROWS - 1);
  localparam logic signed [9:0] CM1 = 10'(GRID_COLS - 1);

  localparam logic [3:0] ST_CLEAR = 4'd0;
  localparam logic [3:0] ST_IDLE  = 4'd1;
  localparam logic [3:0] ST_WR1   = 4'd2;
  localparam logic [3:0] ST_WR2   = 4'd3;
  localparam logic [3:0] ST_RD    = 4'd4;
  localparam logic [3:0] ST_RDM   = 4'd5;
  localparam logic [3:0] ST_RDF   = 4'd6;
  localparam logic [3:0] ST_ADV   = 4'd7;
  localparam logic [3:0] ST_DONE  = 4'd8;

  logic [3:0]        state_r;
  dwgs_pkg::item_t   itm_r;
  logic [AW-1:0]     clr_r;
  logic [NW-1:0]     n_r;
  logic [RW-1:0]     crow_r;
  logic [CW-1:0]     ccol_r;
  logic [2:0]        step_r;
  logic [1:0]        cur_sel_r, prev_sel_r;
  logic signed [HW-1:0] rv_r [5];
  logic signed [HW+10:0] prodx_r, prody_r;
  logic signed [HW-1:0] res_h_r, res_x_r, res_y_r;
  logic                 out_valid_r;
  logic signed [HW-1:0] out_h_r, out_x_r, out_y_r;

  // sweep pipeline
  logic signed [HW-1:0] sh_r [SHD];
  logic                 v1_r, v2_r, v3_r, v4_r, v5_r, v6_r;
  logic [AW-1:0]        a1_r, a2_r, a3_r, a4_r, a5_r, a6_r;
  logic signed [HW:0]   sx2_r, sy2_r;
  logic signed [HW-1:0] cc2_r, pv2_r, pv3_r, cur3_r, nv4_r, cur4_r, fn6_r, fc6_r;
  logic                 ld2_r, ld3_r;
  logic signed [40:0]   px3_r, py3_r;
  logic signed [42:0]   pc3_r;
  logic signed [41:0]   dn5_r, dc5_r;

  // memory ports
  logic                 bk_we [3];
  logic [AW-1:0]        bk_wa [3];
  logic signed [HW-1:0] bk_wd [3];
  logic [AW-1:0]        bk_ra [3];
  logic signed [HW-1:0] bk_rd [3];
  logic                 land_mem [CELLS];
  logic                 land_rd, land_we, land_wd;
  logic [AW-1:0]        land_wa;

  logic [31:0]          k_lin, ra_lin;
  logic [AW-1:0]        k_addr, cur_ra, prev_ra, caddr;
  logic signed [HW-1:0] cur_rd, prev_rd, cur_wd;
  logic                 cur_we, interior, c_int, adv_issue;
  logic signed [47:0]   acc, accs;
  logic signed [HW:0]   negdx, negdy;
  logic                 out_free;

  assign clearing = (state_r == ST_CLEAR);
  assign item_pop = (state_r == ST_IDLE) && item_valid;
  assign out_free = !out_valid_r || out_ch.ready;
  assign interior = (itm_r.row_pos == dwgs_pkg::POS_MID) && (itm_r.col_pos == dwgs_pkg::POS_MID);

  assign k_lin  = 32'(itm_r.row) * 32'(GRID_COLS) + 32'(itm_r.col);
  assign k_addr = k_lin[AW-1:0];
  assign caddr  = AW'(n_r - NW'(GRID_COLS + 1));

  // read address for the neighbour fetches of a read item
  always_comb begin
    case (step_r)
      3'd1:    ra_lin = (itm_r.row_pos == dwgs_pkg::POS_LAST) ? k_lin : k_lin + 32'(GRID_COLS);
      3'd2:    ra_lin = (itm_r.row_pos == dwgs_pkg::POS_FIRST) ? k_lin : k_lin - 32'(GRID_COLS);
      3'd3:    ra_lin = (itm_r.col_pos == dwgs_pkg::POS_LAST) ? k_lin : k_lin + 32'd1;
      3'd4:    ra_lin = (itm_r.col_pos == dwgs_pkg::POS_FIRST) ? k_lin : k_lin - 32'd1;
      default: ra_lin = k_lin;
    endcase
  end

  always_comb begin
    case (state_r)
      ST_ADV:  cur_ra = n_r[AW-1:0];
      ST_RD:   cur_ra = ra_lin[AW-1:0];
      default: cur_ra = k_addr;
    endcase
  end
  assign prev_ra = caddr;
  assign cur_rd  = bk_rd[cur_sel_r];
  assign prev_rd = bk_rd[prev_sel_r];
  assign cur_we  = (state_r == ST_WR2) && interior;
  assign cur_wd  = dwgs_pkg::sat_h(48'(cur_rd) + 48'(itm_r.add));

  // map role ports onto the three physical banks
  always_comb begin
    for (int b = 0; b < 3; b++) begin
      bk_we[b] = 1'b0;
      bk_wa[b] = clr_r;
      bk_wd[b] = '0;
      bk_ra[b] = (2'(b) == prev_sel_r) ? prev_ra : cur_ra;
      if (state_r == ST_CLEAR) begin
        bk_we[b] = 1'b1;
      end else if (2'(b) == cur_sel_r) begin
        bk_we[b] = cur_we;
        bk_wa[b] = k_addr;
        bk_wd[b] = cur_wd;
      end else if (2'(b) == prev_sel_r) begin
        bk_we[b] = v6_r;
        bk_wa[b] = a6_r;
        bk_wd[b] = fn6_r;
      end else begin
        bk_we[b] = v6_r;
        bk_wa[b] = a6_r;
        bk_wd[b] = fc6_r;
      end
    end
  end

  for (genvar g = 0; g < 3; g++) begin : g_bank
    logic signed [HW-1:0] mem [CELLS];
    logic signed [HW-1:0] rd_q;
    always_ff @(posedge clk) begin
      if (bk_we[g]) begin
        mem[bk_wa[g]] <= bk_wd[g];
      end
      rd_q <= mem[bk_ra[g]];
    end
    assign bk_rd[g] = rd_q;
  end

  assign land_we = clearing || (state_r == ST_WR2);
  assign land_wa = clearing ? clr_r : k_addr;
  assign land_wd = clearing ? 1'b0 : itm_r.land;

  always_ff @(posedge clk) begin
    if (land_we) begin
      land_mem[land_wa] <= land_wd;
    end
    land_rd <= land_mem[caddr];
  end

  // centre of the stencil window lags the stream by one row and one cell
  assign c_int = (n_r >= NW'(GRID_COLS + 1)) && (n_r <= NW'(CELLS + GRID_COLS))
              && (crow_r != '0) && (crow_r != RW'(GRID_ROWS - 1))
              && (ccol_r != '0) && (ccol_r != CW'(GRID_COLS - 1));
  assign adv_issue = (state_r == ST_ADV) && c_int;
  assign acc  = 48'(px3_r) + 48'(py3_r) + 48'(pc3_r) + 48'sd32768;
  assign accs = (acc >>> 16) - 48'(pv3_r);

  always_ff @(posedge clk) begin
    if (state_r == ST_ADV) begin
      sh_r[0] <= cur_rd;
      for (int i = 1; i < SHD; i++) begin
        sh_r[i] <= sh_r[i-1];
      end
    end
    a1_r   <= caddr;
    a2_r   <= a1_r;
    sx2_r  <= (HW+1)'(sh_r[2*GRID_COLS]) + (HW+1)'(sh_r[0]);
    sy2_r  <= (HW+1)'(sh_r[GRID_COLS+1]) + (HW+1)'(sh_r[GRID_COLS-1]);
    cc2_r  <= sh_r[GRID_COLS];
    pv2_r  <= prev_rd;
    ld2_r  <= land_rd;
    a3_r   <= a2_r;
    px3_r  <= $signed({1'b0, cfg.coef_x}) * sx2_r;
    py3_r  <= $signed({1'b0, cfg.coef_y}) * sy2_r;
    pc3_r  <= $signed({1'b0, cfg.coef_center}) * cc2_r;
    pv3_r  <= pv2_r;
    ld3_r  <= ld2_r;
    cur3_r <= cc2_r;
    a4_r   <= a3_r;
    nv4_r  <= ld3_r ? '0 : dwgs_pkg::sat_h(accs);
    cur4_r <= cur3_r;
    a5_r   <= a4_r;
    dn5_r  <= $signed({1'b0, cfg.damping}) * nv4_r;
    dc5_r  <= $signed({1'b0, cfg.damping}) * cur4_r;
    a6_r   <= a5_r;
    fn6_r  <= dwgs_pkg::sat_h((48'(dn5_r) + 48'sd32768) >>> 16);
    fc6_r  <= dwgs_pkg::sat_h((48'(dc5_r) + 48'sd32768) >>> 16);
  end

  assign negdx = (HW+1)'(rv_r[2]) - (HW+1)'(rv_r[1]);
  assign negdy = (HW+1)'(rv_r[4]) - (HW+1)'(rv_r[3]);

  // payload registers of the sequencer
  always_ff @(posedge clk) begin
    if (item_pop) begin
      itm_r   <= item;
      res_h_r <= '0;
      res_x_r <= '0;
      res_y_r <= '0;
    end
    if (state_r == ST_RD && step_r != 3'd0) begin
      rv_r[step_r - 3'd1] <= cur_rd;
    end
    if (state_r == ST_RDM) begin
      prodx_r <= negdx * RM1;
      prody_r <= negdy * CM1;
    end
    if (state_r == ST_RDF) begin
      res_h_r <= rv_r[0];
      res_x_r <= (itm_r.row_pos == dwgs_pkg::POS_MID)
               ? dwgs_pkg::sat_h((48'(prodx_r) + 48'sd8) >>> 4)
               : dwgs_pkg::sat_h((48'(prodx_r) + 48'sd4) >>> 3);
      res_y_r <= (itm_r.col_pos == dwgs_pkg::POS_MID)
               ? dwgs_pkg::sat_h((48'(prody_r) + 48'sd8) >>> 4)
               : dwgs_pkg::sat_h((48'(prody_r) + 48'sd4) >>> 3);
    end
    if (state_r == ST_DONE && out_free) begin
      out_h_r <= res_h_r;
      out_x_r <= res_x_r;
      out_y_r <= res_y_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_r       <= '0;
      n_r         <= '0;
      crow_r      <= '0;
      ccol_r      <= '0;
      step_r      <= '0;
      cur_sel_r   <= 2'd0;
      prev_sel_r  <= 2'd1;
      out_valid_r <= 1'b0;
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      v4_r        <= 1'b0;
      v5_r        <= 1'b0;
      v6_r        <= 1'b0;
    end else begin
      v1_r <= adv_issue;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
      v5_r <= v4_r;
      v6_r <= v5_r;
      // in ST_DONE the result register is reloaded below instead
      if (out_valid_r && out_ch.ready && (state_r != ST_DONE)) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_CLEAR: begin
          clr_r <= clr_r + AW'(1);
          if (clr_r == AW'(CELLS - 1)) begin
            state_r <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (item_valid) begin
            n_r    <= '0;
            crow_r <= '0;
            ccol_r <= '0;
            step_r <= '0;
            case (item.op)
              dwgs_pkg::OP_WRITE:   state_r <= ST_WR1;
              dwgs_pkg::OP_ADVANCE: state_r <= ST_ADV;
              dwgs_pkg::OP_READ:    state_r <= ST_RD;
              default:              state_r <= ST_DONE;
            endcase
          end
        end
        ST_WR1: state_r <= ST_WR2;
        ST_WR2: state_r <= ST_DONE;
        ST_RD: begin
          step_r <= step_r + 3'd1;
          if (step_r == 3'd5) begin
            state_r <= ST_RDM;
          end
        end
        ST_RDM: state_r <= ST_RDF;
        ST_RDF: state_r <= ST_DONE;
        ST_ADV: begin
          n_r <= n_r + NW'(1);
          if (n_r >= NW'(GRID_COLS + 1)) begin
            if (ccol_r == CW'(GRID_COLS - 1)) begin
              ccol_r <= '0;
              crow_r <= crow_r + RW'(1);
            end else begin
              ccol_r <= ccol_r + CW'(1);
            end
          end
          if (n_r == NW'(N_END)) begin
            // new grid sits in the old previous bank, damped current in the spare
            cur_sel_r  <= prev_sel_r;
            prev_sel_r <= 2'd3 - cur_sel_r - prev_sel_r;
            state_r    <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            state_r     <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign out_ch.valid    = out_valid_r;
  assign out_ch.height   = out_h_r;
  assign out_ch.normal_x = out_x_r;
  assign out_ch.normal_y = out_y_r;

  `DWGS_ASSERT_IMPL(a_roles_distinct, 1'b1, (cur_sel_r != prev_sel_r) && (cur_sel_r != 2'd3) && (prev_sel_r != 2'd3), "bank roles overlap")
  `DWGS_ASSERT_IMPL(a_sweep_write_in_adv, v6_r, state_r == ST_ADV, "sweep write outside advance")
  `DWGS_ASSERT_NEXT(a_result_loaded, (state_r == ST_DONE) && out_free, out_valid_r && (state_r == ST_IDLE), "result not loaded")
  `DWGS_ASSERT_IMPL(a_no_result_in_clear, state_r == ST_CLEAR, !out_valid_r, "result during clearing pass")
endmodule
`default_nettype wire

@@ rtl/damped_wave_grid_stencil_unit.sv @@
// Top level of the damped wave grid stencil unit: configuration registers,
// front end and back end. Depends on dwgs_pkg, dwgs_if, dwgs_front, dwgs_back.
`timescale 1ns / 1ps
`default_nettype none
// Channel  | Dir | Handshake          | Payload
// in_ch    | in  | valid/ready        | req_type, row, col, land_flag, height_add
// out_ch   | out | valid/ready        | height, normal_x, normal_y (one per request)
// cfg_*    | in  | cfg_wr_en strobe   | cfg_index, cfg_data (coef_x, coef_y, coef_center, damping)
//
// Advance streams one cell per cycle through the single read port of the current bank.
// Reset: a clearing pass zeroes banks and land mask; in_ch.ready stays low meanwhile.
// Stalls: a two-entry queue takes transactions while the back end works or a
//   result waits in the output register.
module damped_wave_grid_stencil_unit #(
  parameter int GRID_ROWS = dwgs_pkg::DEF_GRID_ROWS,
  parameter int GRID_COLS = dwgs_pkg::DEF_GRID_COLS
) (
  input  logic                                clk,
  input  logic                                rst_n,
  dwgs_in_if.sink                             in_ch,
  dwgs_out_if.source                          out_ch,
  input  logic                                cfg_wr_en,
  input  logic [dwgs_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [dwgs_pkg::CFG_DATA_W-1:0]     cfg_data
);
  dwgs_pkg::cfg_t  cfg_r;
  dwgs_pkg::item_t head;
  logic            head_valid;
  logic            pop;
  logic            clearing;

  // Configuration registers; fields take the low bits of the written data.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.coef_x      <= dwgs_pkg::RST_COEF_X;
      cfg_r.coef_y      <= dwgs_pkg::RST_COEF_Y;
      cfg_r.coef_center <= dwgs_pkg::RST_COEF_CENTER;
      cfg_r.damping     <= dwgs_pkg::RST_DAMPING;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        dwgs_pkg::CFG_COEF_X:      cfg_r.coef_x      <= cfg_data[dwgs_pkg::CX_W-1:0];
        dwgs_pkg::CFG_COEF_Y:      cfg_r.coef_y      <= cfg_data[dwgs_pkg::CY_W-1:0];
        dwgs_pkg::CFG_COEF_CENTER: cfg_r.coef_center <= cfg_data[dwgs_pkg::CC_W-1:0];
        dwgs_pkg::CFG_DAMPING:     cfg_r.damping     <= cfg_data[dwgs_pkg::DAMP_W-1:0];
        default:                   cfg_r             <= cfg_r;
      endcase
    end
  end

  // Front end: decode and queue each transaction.
  dwgs_front #(
    .GRID_ROWS (GRID_ROWS),
    .GRID_COLS (GRID_COLS)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .hold       (clearing),
    .head       (head),
    .head_valid (head_valid),
    .pop        (pop)
  );

  // Back end: memories, sweep pipeline and result register.
  dwgs_back #(
    .GRID_ROWS (GRID_ROWS),
    .GRID_COLS (GRID_COLS)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .item       (head),
    .item_valid (head_valid),
    .item_pop   (pop),
    .clearing   (clearing),
    .cfg        (cfg_r),
    .out_ch     (out_ch)
  );
endmodule
`default_nettype wire
